// ===== hdl/ustc_pkg.sv =====
// ----------------------------------------------------------------------------
// ustc_pkg
// Shared types and constants for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ustc_pkg;

  // Time of day travels as one group beside the date arithmetic.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // Reciprocal for n / 15, exact for n below 2^34 / 11, taken with a shift of 34.
  localparam logic [30:0] DIV15_MUL = 31'h4444_4445;
  localparam int unsigned DIV15_SHIFT = 34;

  // Reciprocal for n / 3, exact for n below 2^19, taken with a shift of 19.
  localparam logic [17:0] DIV3_MUL = 18'd174763;

  // Reciprocal for n / 1461, exact for n below 94519, taken with a shift of 26.
  localparam logic [15:0] DIV1461_MUL = 16'd45934;

  // The date math counts days from 1968-01-01, the start of a leap cycle.
  localparam logic [15:0] EPOCH_DAY_OFFSET = 16'd731;
  localparam logic [11:0] YEAR_BASE        = 12'd1968;
  localparam logic [15:0] DAYS_PER_CYCLE   = 16'd1461;

  // Day count since 1970 of 2100-03-01; from there on one day is skipped so
  // that the plain four-year cycle never produces a 29 February in 2100.
  localparam logic [15:0] SKIP_DAY_FIRST = 16'd47541;

  // First day of each month within a common year.
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  function automatic logic [8:0] month_first_day(input logic [3:0] idx, input logic leap);
    logic [8:0] start;
    start = MONTH_START[idx];
    if (leap && (idx >= 4'd2)) begin
      start = start + 9'd1;
    end
    return start;
  endfunction

endpackage

// ===== hdl/ustc_tod_div.sv =====
// ----------------------------------------------------------------------------
// ustc_tod_div
// Four-stage divider chain: seconds to whole days and time of day.
// ----------------------------------------------------------------------------
module ustc_tod_div
  import ustc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] secs,
  output logic        out_valid,
  output logic [15:0] days,
  output tod_t        tod
);

  logic        s1_valid, s2_valid, s3_valid;
  logic [31:0] s1_x;
  logic [60:0] s1_prod;
  logic [26:0] s2_q1;
  logic [55:0] s2_prod;
  logic [5:0]  s2_sec;
  logic [20:0] s3_q2;
  logic [35:0] s3_prod;
  logic [5:0]  s3_sec;
  logic [5:0]  s3_min;

  logic [26:0] q1;
  logic [31:0] rem_s;
  logic [20:0] q2;
  logic [26:0] rem_m;
  logic [15:0] day_cnt;
  logic [20:0] rem_h;

  // Minutes: x / 60 is (x >> 2) / 15.
  assign q1    = s1_prod[60:DIV15_SHIFT];
  assign rem_s = s1_x - 32'(q1) * 32'd60;
  // Hours: minutes / 60 is (minutes >> 2) / 15.
  assign q2    = s2_prod[54:DIV15_SHIFT];
  assign rem_m = s2_q1 - 27'(q2) * 27'd60;
  // Days: hours / 24 is (hours >> 3) / 3.
  assign day_cnt = s3_prod[34:19];
  assign rem_h   = s3_q2 - 21'(day_cnt) * 21'd24;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x       <= secs;
      s1_prod    <= 61'(secs[31:2]) * 61'(DIV15_MUL);
      s2_q1      <= q1;
      s2_sec     <= rem_s[5:0];
      s2_prod    <= 56'(q1[26:2]) * 56'(DIV15_MUL);
      s3_q2      <= q2;
      s3_sec     <= s2_sec;
      s3_min     <= rem_m[5:0];
      s3_prod    <= 36'(q2[20:3]) * 36'(DIV3_MUL);
      days       <= day_cnt;
      tod.second <= s3_sec;
      tod.minute <= s3_min;
      tod.hour   <= rem_h[4:0];
    end
  end

endmodule

// ===== hdl/ustc_date.sv =====
// ----------------------------------------------------------------------------
// ustc_date
// Six-stage conversion of a day count into year, month and day of month.
// ----------------------------------------------------------------------------
module ustc_date
  import ustc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] days,
  input  tod_t        tod_in,
  output logic        out_valid,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output tod_t        tod_out
);

  logic [4:0]  valid_pipe;
  tod_t        tod_pipe [5];

  logic [15:0] d1_e;
  logic [15:0] d2_e;
  logic [31:0] d2_prod;
  logic [5:0]  d3_cyc;
  logic [10:0] d3_r;
  logic [11:0] d4_year;
  logic [8:0]  d4_doy;
  logic        d4_leap;
  logic [11:0] d5_year;
  logic [8:0]  d5_doy;
  logic        d5_leap;
  logic [3:0]  d5_midx;

  logic        skip;
  logic [15:0] e_next;
  logic [5:0]  cyc;
  logic [15:0] rem_c;
  logic [1:0]  yoff;
  logic [8:0]  doy_next;
  logic [3:0]  midx_next;
  logic [8:0]  mstart;

  assign skip   = (days >= SKIP_DAY_FIRST);
  assign e_next = days + EPOCH_DAY_OFFSET + 16'(skip);

  assign cyc   = d2_prod[31:26];
  assign rem_c = d2_e - 16'(cyc) * DAYS_PER_CYCLE;

  // Year within the cycle: the first is the leap year of 366 days.
  always_comb begin
    if (d3_r < 11'd366) begin
      yoff     = 2'd0;
      doy_next = d3_r[8:0];
    end else if (d3_r < 11'd731) begin
      yoff     = 2'd1;
      doy_next = 9'(d3_r - 11'd366);
    end else if (d3_r < 11'd1096) begin
      yoff     = 2'd2;
      doy_next = 9'(d3_r - 11'd731);
    end else begin
      yoff     = 2'd3;
      doy_next = 9'(d3_r - 11'd1096);
    end
  end

  // Month index is the number of later month starts already reached.
  always_comb begin
    midx_next = 4'd0;
    for (int m = 1; m < 12; m++) begin
      midx_next = midx_next + 4'(d4_doy >= month_first_day(4'(m), d4_leap));
    end
  end

  assign mstart = month_first_day(d5_midx, d5_leap);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
      out_valid  <= 1'b0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[3:0], in_valid};
      out_valid  <= valid_pipe[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tod_pipe[0]  <= tod_in;
      for (int i = 1; i < 5; i++) begin
        tod_pipe[i] <= tod_pipe[i-1];
      end
      tod_out      <= tod_pipe[4];
      d1_e         <= e_next;
      d2_e         <= d1_e;
      d2_prod      <= 32'(d1_e) * 32'(DIV1461_MUL);
      d3_cyc       <= cyc;
      d3_r         <= rem_c[10:0];
      d4_year      <= YEAR_BASE + 12'({d3_cyc, 2'b00}) + 12'(yoff);
      d4_doy       <= doy_next;
      d4_leap      <= (yoff == 2'd0);
      d5_year      <= d4_year;
      d5_doy       <= d4_doy;
      d5_leap      <= d4_leap;
      d5_midx      <= midx_next;
      year         <= d5_year;
      month        <= d5_midx + 4'd1;
      day_of_month <= 5'(d5_doy - mstart + 9'd1);
    end
  end

endmodule

// ===== hdl/unix_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Pipelined conversion of a 32-bit seconds count into UTC calendar fields.
// ----------------------------------------------------------------------------
// Each input word is a count of seconds since 1970-01-01 00:00:00 UTC, and
// each output word carries the matching UTC year, month, day of month, hour,
// minute and second, with Gregorian leap years and no leap seconds. Every
// input word gives exactly one output word, in order. The block is a ten
// stage pipeline that takes one word per clock as long as the output side
// keeps up. The whole pipeline advances together: while a finished word
// waits at the output under stall, in_stall is raised and every stage
// holds, so nothing is lost or repeated. The first four stages split the
// seconds into whole days and time of day with reciprocal multiplications
// (one in every stage but the fourth); the last six turn the day count into
// a date through the four-year leap cycle, with a one-day correction for
// the common year 2100, and a month search over a constant table. There
// are no registers to configure and no state is kept between words.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar
  import ustc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] unix_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic        en;
  logic        mid_valid;
  logic [15:0] mid_days;
  tod_t        mid_tod;
  tod_t        out_tod;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Seconds to days plus hour, minute and second.
  ustc_tod_div u_tod_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .secs      (unix_seconds),
    .out_valid (mid_valid),
    .days      (mid_days),
    .tod       (mid_tod)
  );

  // Days to year, month and day; the time of day rides alongside.
  ustc_date u_date (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (mid_valid),
    .days         (mid_days),
    .tod_in       (mid_tod),
    .out_valid    (out_valid),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .tod_out      (out_tod)
  );

  assign hour   = out_tod.hour;
  assign minute = out_tod.minute;
  assign second = out_tod.second;

`ifndef SYNTHESIS
  // Month and day must form a real date.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12) &&
                  (day_of_month >= 5'd1) && (day_of_month <= 5'd31))
    else $error("month or day out of range");

  // February never passes its 29th, and never its 28th in a common year.
  a_february: assert property (@(posedge clk) disable iff (rst)
    out_valid && (month == 4'd2) |->
      (day_of_month <= 5'd29) &&
      ((day_of_month != 5'd29) || ((year[1:0] == 2'b00) && (year != 12'd2100))))
    else $error("invalid February date");

  // The remainders of the divider chain stay below their divisors.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("time of day out of range");
`endif

endmodule

// ===== tb/tb_unix_seconds_to_calendar.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar
// Self-checking testbench for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
// A list of seconds counts is built up front: a directed set of boundary
// instants, followed by random counts. Some are uniform over the full 32-bit
// range, some sit on or next to a day, hour or minute boundary, and some lie
// close to the top of the range. A clocked driver offers the counts one word
// at a time with random gaps. A clocked monitor takes the calendar words
// with random stall. Every accepted input word is converted by a behavioral
// calendar routine in this file, and each output word is compared field by
// field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_calendar;
  import ustc_pkg::*;

  // Number of random words on top of the directed set.
  localparam int RANDOM_WORDS = 1330;
  // Cycles with no word accepted on either side before the run is declared hung.
  localparam int HANG_LIMIT   = 5000;
  // Cycles to keep watching the output after the last expected word arrived.
  // The pipeline is ten stages deep.
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_WAIT     = 18;

  localparam longint unsigned SECONDS_MAX  = 64'hFFFF_FFFF;
  localparam int unsigned     SECS_PER_DAY = 86400;
  localparam int unsigned     LAST_DAY     = 49710;

  localparam int unsigned DAYS_IN_MONTH [12] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  // One predicted calendar word.
  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    tod_t        tod;
  } calendar_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [31:0] unix_seconds = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  logic [31:0] pending_seconds [$];
  calendar_t   expected_dates [$];
  int          failures    = 0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          idle_cycles = 0;
  // While a side is "calm" it neither idles nor stalls; the flag flips now and
  // then so that long back-to-back stretches alternate with ragged traffic.
  bit          send_calm   = 1'b0;
  bit          recv_calm   = 1'b0;

  unix_seconds_to_calendar i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .unix_seconds (unix_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
  endfunction

  // Behavioral conversion: peel off seconds, minutes and hours, then walk the
  // remaining whole days through years and months from the 1970 epoch.
  function automatic calendar_t to_calendar(input logic [31:0] secs);
    calendar_t   date;
    int unsigned rest;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    bit          leap;
    rest = secs;
    date.tod.second = 6'(rest % 60);
    rest = rest / 60;
    date.tod.minute = 6'(rest % 60);
    rest = rest / 60;
    date.tod.hour = 5'(rest % 24);
    rest = rest / 24;
    yr = 1970;
    while (rest >= (is_leap_year(yr) ? 366 : 365)) begin
      rest = rest - (is_leap_year(yr) ? 366 : 365);
      yr = yr + 1;
    end
    leap = is_leap_year(yr);
    mon = 0;
    while (mon < 11) begin
      mlen = DAYS_IN_MONTH[mon] + ((mon == 1 && leap) ? 1 : 0);
      if (rest < mlen) begin
        break;
      end
      rest = rest - mlen;
      mon = mon + 1;
    end
    date.year         = 12'(yr);
    date.month        = 4'(mon + 1);
    date.day_of_month = 5'(rest + 1);
    return date;
  endfunction

  // Cycles to idle after a word: often none, otherwise anywhere up to the max.
  function automatic int draw_wait(input bit calm);
    if (calm || ($urandom_range(0, 3) == 0)) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // Random seconds count. Uniform words exercise every input bit; the others
  // land on day, hour and minute edges, where carries ripple into the date,
  // or near the very end of the 32-bit range.
  function automatic logic [31:0] random_seconds();
    longint unsigned secs;
    int unsigned     offset;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: secs = $urandom();
      4: secs = SECONDS_MAX - $urandom_range(0, 200000);
      default: begin
        case ($urandom_range(0, 6))
          0: offset = 0;
          1: offset = 59;
          2: offset = 60;
          3: offset = 3599;
          4: offset = 3600;
          5: offset = SECS_PER_DAY - 1;
          default: offset = $urandom_range(0, SECS_PER_DAY - 1);
        endcase
        secs = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY + offset;
        if (secs > SECONDS_MAX) begin
          secs = SECONDS_MAX - $urandom_range(0, SECS_PER_DAY - 1);
        end
      end
    endcase
    return secs[31:0];
  endfunction

  // Stimulus list, reset, and the end-of-run decision.
  initial begin
    // Epoch, the last count, and both sides of each minute, hour and day boundary.
    pending_seconds.push_back(32'd0);
    pending_seconds.push_back(32'hFFFF_FFFF);
    pending_seconds.push_back(32'd59);
    pending_seconds.push_back(32'd60);
    pending_seconds.push_back(32'd3599);
    pending_seconds.push_back(32'd3600);
    pending_seconds.push_back(32'd86399);
    pending_seconds.push_back(32'd86400);
    // End of the first year, the first leap day of the range in 1972, and the end of 1972.
    pending_seconds.push_back(32'd31535999);
    pending_seconds.push_back(32'd68169600);
    pending_seconds.push_back(32'd94694399);
    // The century year 2000 is a leap year: around 29 February and New Year.
    pending_seconds.push_back(32'd946684799);
    pending_seconds.push_back(32'd951782399);
    pending_seconds.push_back(32'd951782400);
    pending_seconds.push_back(32'd951868800);
    pending_seconds.push_back(32'd978307199);
    // The signed 32-bit rollover in 2038.
    pending_seconds.push_back(32'd2147483647);
    pending_seconds.push_back(32'd2147483648);
    // The century year 2100 is a common year: 28 February runs into 1 March.
    pending_seconds.push_back(32'd4107456000);
    pending_seconds.push_back(32'd4107542399);
    pending_seconds.push_back(32'd4107542400);
    pending_seconds.push_back(32'd4133980799);
    // New Year of the last year in range.
    pending_seconds.push_back(32'd4291747200);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pending_seconds.push_back(random_seconds());
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sampled on the falling edge so that the driver and monitor have settled.
    do begin
      @(negedge clk);
    end while (pending_seconds.size() != 0 || in_valid || expected_dates.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("unix_seconds_to_calendar test passed");
    end else begin
      $display("unix_seconds_to_calendar test failed");
    end
    $finish;
  end

  // Input driver. A word held under in_stall stays put; otherwise an accepted
  // word is converted into its prediction, and the next word goes out once
  // the gap drawn for the previous one has run down.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_dates.push_back(to_calendar(unix_seconds));
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_seconds.size() != 0) begin
        in_valid     <= 1'b1;
        unix_seconds <= pending_seconds.pop_front();
        gap_left     <= draw_wait(send_calm);
        if ($urandom_range(0, 99) == 0) begin
          send_calm <= !send_calm;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor. Each accepted calendar word is checked against the oldest
  // prediction, and a fresh stall length is drawn for the word that follows.
  always @(posedge clk) begin : result_monitor
    calendar_t want;
    int        hold;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, year, month, day_of_month, hour, minute, second);
        failures++;
      end else begin
        want = expected_dates.pop_front();
        check_field("year", want.year, year);
        check_field("month", want.month, month);
        check_field("day_of_month", want.day_of_month, day_of_month);
        check_field("hour", want.tod.hour, hour);
        check_field("minute", want.tod.minute, minute);
        check_field("second", want.tod.second, second);
      end
      hold = draw_wait(recv_calm);
      stall_left <= hold;
      out_stall  <= (hold != 0);
      if ($urandom_range(0, 99) == 0) begin
        recv_calm <= !recv_calm;
      end
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Hang detector: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
      $display("unix_seconds_to_calendar test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
